[design/eva_pkg.sv]
package eva_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] CFG_STEP_MODE    = 3'd0;
    localparam logic [2:0] CFG_ENTROPY_MODE = 3'd1;
    localparam logic [2:0] CFG_BETA         = 3'd2;
    localparam logic [2:0] CFG_RESIDUAL     = 3'd3;
    localparam logic [2:0] CFG_INV_DT       = 3'd4;
    localparam logic [2:0] CFG_MEAN         = 3'd5;
    localparam logic [2:0] CFG_INV_EV       = 3'd6;
    localparam logic [2:0] CFG_DSCALE       = 3'd7;

    localparam logic [1:0] STEP_ZERO_VEL = 2'd0;
    localparam logic [1:0] STEP_FIRST    = 2'd1;

    typedef struct packed {
        logic [32:0] dc;
        logic [31:0] ux;
        logic [31:0] uy;
        logic [31:0] gx;
        logic [31:0] gy;
        logic [31:0] tavg;
        logic [31:0] h;
        logic        last;
    } entry_t;

    typedef struct packed {
        logic [1:0]  step_mode;
        logic        entropy_mode;
        logic [31:0] beta;
        logic [31:0] resid;
        logic [31:0] inv_dt;
        logic [31:0] mean;
        logic [31:0] inv_ev;
        logic [31:0] dscale;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [32:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic        sat;
        logic [63:0] value;
        logic [63:0] low;
    } mul_rsp_t;

endpackage

[design/eva_front.sv]
module eva_front
    import eva_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [31:0]  s_conc_now,
    input  logic [31:0]  s_conc_before,
    input  logic [31:0]  s_grad_now_x,
    input  logic [31:0]  s_grad_now_y,
    input  logic [31:0]  s_grad_before_x,
    input  logic [31:0]  s_grad_before_y,
    input  logic [31:0]  s_vel_now_x,
    input  logic [31:0]  s_vel_now_y,
    input  logic [31:0]  s_vel_before_x,
    input  logic [31:0]  s_vel_before_y,
    input  logic [31:0]  s_cell_size,
    input  logic         s_last_point,
    output logic         out_valid,
    input  logic         out_ready,
    output entry_t       out_entry
);

    function automatic logic [31:0] avg2(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        logic [32:0] r;
        s = {a[31], a} + {b[31], b};
        r = s[32] ? (s + 33'd1) : s;
        return r[32:1];
    endfunction

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   accept;

    assign s_ready   = !valid_reg || out_ready;
    assign accept    = s_valid && s_ready;
    assign out_valid = valid_reg;
    assign out_entry = entry_reg;

    always_comb begin
        entry_next.dc   = {s_conc_now[31], s_conc_now} - {s_conc_before[31], s_conc_before};
        entry_next.ux   = avg2(s_vel_now_x, s_vel_before_x);
        entry_next.uy   = avg2(s_vel_now_y, s_vel_before_y);
        entry_next.gx   = avg2(s_grad_now_x, s_grad_before_x);
        entry_next.gy   = avg2(s_grad_now_y, s_grad_before_y);
        entry_next.tavg = avg2(s_conc_now, s_conc_before);
        entry_next.h    = s_cell_size;
        entry_next.last = s_last_point;
        if (accept) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (accept) begin
            entry_reg <= entry_next;
        end
    end

endmodule

[design/eva_queue.sv]
module eva_queue
    import eva_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   wr_valid,
    output logic   wr_ready,
    input  entry_t wr_data,
    output logic   rd_valid,
    input  logic   rd_ready,
    output entry_t rd_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               push;
    logic               pop;

    assign wr_ready = cnt_reg != CNT_W'(QUEUE_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[design/eva_mul.sv]
module eva_mul
    import eva_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [1:0]  phase_reg;
    logic [31:0] a_hi_reg;
    logic [32:0] b_reg;
    logic [64:0] p0_reg;
    logic [64:0] p1_reg;
    logic [96:0] full;

    assign full      = {p1_reg, 32'd0} + {32'd0, p0_reg};
    assign rsp.done  = phase_reg == 2'd2;
    assign rsp.sat   = |full[96:64+FRAC_BITS];
    assign rsp.value = rsp.sat ? '1 : full[63+FRAC_BITS:FRAC_BITS];
    assign rsp.low   = full[63:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 2'd0;
        end else begin
            case (phase_reg)
                2'd0:    phase_reg <= req.start ? 2'd1 : 2'd0;
                2'd1:    phase_reg <= 2'd2;
                default: phase_reg <= 2'd0;
            endcase
        end
        if (req.start) begin
            p0_reg   <= 65'({33'd0, req.a[31:0]} * {32'd0, req.b});
            a_hi_reg <= req.a[63:32];
            b_reg    <= req.b;
        end
        if (phase_reg == 2'd1) begin
            p1_reg <= 65'({33'd0, a_hi_reg} * {32'd0, b_reg});
        end
    end

endmodule

[design/eva_back.sv]
module eva_back
    import eva_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        q_valid,
    output logic        q_ready,
    input  entry_t      q_data,
    output mul_req_t    mreq,
    input  mul_rsp_t    mrsp,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_viscosity,
    output logic        m_saturated
);

    localparam logic [32:0] ZV_COEF = 33'(((5 << FRAC_BITS) + 500) / 1000);
    localparam logic [63:0] MASK32  = 64'h0000_0000_FFFF_FFFF;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SPX, ST_SPY, ST_DT, ST_UGX, ST_UGY, ST_ENT, ST_UPD,
        ST_ZV, ST_SQRT, ST_B1, ST_B2, ST_E0, ST_E1, ST_E2, ST_E3, ST_CLAMP
    } state_t;

    function automatic logic [32:0] mag32(input logic [31:0] v);
        logic [32:0] n;
        n = 33'd0 - {v[31], v};
        return v[31] ? n : {1'b0, v};
    endfunction

    function automatic logic [32:0] mag33(input logic [32:0] v);
        logic [33:0] n;
        n = 34'd0 - {v[32], v};
        return v[32] ? n[32:0] : v;
    endfunction

    state_t      state_reg, state_next;
    logic        issued_reg, issued_next;
    entry_t      cur_reg, cur_next;
    logic [65:0] acc_reg, acc_next;
    logic [63:0] spd_reg, spd_next;
    logic [63:0] rmag_reg, rmag_next;
    logic [31:0] peak_res_reg, peak_res_next;
    logic [63:0] peak_spd_reg, peak_spd_next;
    logic [63:0] sq_v_reg, sq_v_next;
    logic [63:0] sq_res_reg, sq_res_next;
    logic [63:0] sq_bit_reg, sq_bit_next;
    logic [4:0]  sq_cnt_reg, sq_cnt_next;
    logic [31:0] vmax_reg, vmax_next;
    logic [63:0] tmp_reg, tmp_next;
    logic [63:0] bound_reg, bound_next;
    logic        flag_reg, flag_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_visc_reg, out_visc_next;
    logic        out_sat_reg, out_sat_next;

    logic        is_mul;
    logic        neg;
    logic [65:0] sum66;
    logic [65:0] abs66;
    logic [32:0] e_mag;
    logic [32:0] e_diff;
    logic [31:0] rclip;
    logic [63:0] sq_sum;

    assign q_ready     = state_reg == ST_IDLE;
    assign m_valid     = out_valid_reg;
    assign m_viscosity = out_visc_reg;
    assign m_saturated = out_sat_reg;

    always_comb begin
        is_mul = 1'b0;
        mreq.a = '0;
        mreq.b = '0;
        neg    = 1'b0;
        e_diff = {cur_reg.tavg[31], cur_reg.tavg} - {cfg.mean[31], cfg.mean};
        e_mag  = mag33(e_diff);
        unique case (state_reg)
            ST_SPX: begin
                is_mul = 1'b1;
                mreq.a = {31'd0, mag32(cur_reg.ux)};
                mreq.b = mag32(cur_reg.ux);
            end
            ST_SPY: begin
                is_mul = 1'b1;
                mreq.a = {31'd0, mag32(cur_reg.uy)};
                mreq.b = mag32(cur_reg.uy);
            end
            ST_DT: begin
                is_mul = 1'b1;
                mreq.a = {32'd0, cfg.inv_dt};
                mreq.b = mag33(cur_reg.dc);
                neg    = cur_reg.dc[32];
            end
            ST_UGX: begin
                is_mul = 1'b1;
                mreq.a = {31'd0, mag32(cur_reg.ux)};
                mreq.b = mag32(cur_reg.gx);
                neg    = cur_reg.ux[31] ^ cur_reg.gx[31];
            end
            ST_UGY: begin
                is_mul = 1'b1;
                mreq.a = {31'd0, mag32(cur_reg.uy)};
                mreq.b = mag32(cur_reg.gy);
                neg    = cur_reg.uy[31] ^ cur_reg.gy[31];
            end
            ST_ENT: begin
                is_mul = 1'b1;
                mreq.a = rmag_reg;
                mreq.b = e_mag;
            end
            ST_ZV: begin
                is_mul = 1'b1;
                mreq.a = {32'd0, cur_reg.h};
                mreq.b = ZV_COEF;
            end
            ST_B1: begin
                is_mul = 1'b1;
                mreq.a = {32'd0, cfg.beta};
                mreq.b = {1'b0, vmax_reg};
            end
            ST_B2: begin
                is_mul = 1'b1;
                mreq.a = tmp_reg;
                mreq.b = {1'b0, cur_reg.h};
            end
            ST_E0: begin
                is_mul = 1'b1;
                mreq.a = {32'd0, cfg.resid};
                mreq.b = {1'b0, cur_reg.h};
            end
            ST_E1: begin
                is_mul = 1'b1;
                mreq.a = tmp_reg;
                mreq.b = {1'b0, cfg.entropy_mode ? cur_reg.h : cfg.dscale};
            end
            ST_E2: begin
                is_mul = 1'b1;
                mreq.a = tmp_reg;
                mreq.b = {1'b0, cfg.entropy_mode ? peak_res_reg : vmax_reg};
            end
            ST_E3: begin
                is_mul = 1'b1;
                mreq.a = tmp_reg;
                mreq.b = {1'b0, cfg.entropy_mode ? cfg.inv_ev : peak_res_reg};
            end
            default: begin
                is_mul = 1'b0;
            end
        endcase
        mreq.start = is_mul && !issued_reg;
        sum66 = neg ? (acc_reg - {2'd0, mrsp.value}) : (acc_reg + {2'd0, mrsp.value});
        abs66 = sum66[65] ? (66'd0 - sum66) : sum66;
        rclip  = (rmag_reg > MASK32) ? 32'hFFFF_FFFF : rmag_reg[31:0];
        sq_sum = sq_res_reg + sq_bit_reg;
    end

    always_comb begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        cur_next       = cur_reg;
        acc_next       = acc_reg;
        spd_next       = spd_reg;
        rmag_next      = rmag_reg;
        peak_res_next  = peak_res_reg;
        peak_spd_next  = peak_spd_reg;
        sq_v_next      = sq_v_reg;
        sq_res_next    = sq_res_reg;
        sq_bit_next    = sq_bit_reg;
        sq_cnt_next    = sq_cnt_reg;
        vmax_next      = vmax_reg;
        tmp_next       = tmp_reg;
        bound_next     = bound_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg;
        out_visc_next  = out_visc_reg;
        out_sat_next   = out_sat_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (mreq.start) begin
            issued_next = 1'b1;
        end else if (mrsp.done) begin
            issued_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cur_next   = q_data;
                    state_next = ST_SPX;
                end
            end
            ST_SPX: begin
                if (mrsp.done) begin
                    spd_next   = mrsp.low;
                    state_next = ST_SPY;
                end
            end
            ST_SPY: begin
                if (mrsp.done) begin
                    spd_next   = spd_reg + mrsp.low;
                    acc_next   = '0;
                    state_next = ST_DT;
                end
            end
            ST_DT: begin
                if (mrsp.done) begin
                    acc_next   = sum66;
                    state_next = ST_UGX;
                end
            end
            ST_UGX: begin
                if (mrsp.done) begin
                    acc_next   = sum66;
                    state_next = ST_UGY;
                end
            end
            ST_UGY: begin
                if (mrsp.done) begin
                    acc_next   = sum66;
                    rmag_next  = abs66[63:0];
                    state_next = cfg.entropy_mode ? ST_ENT : ST_UPD;
                end
            end
            ST_ENT: begin
                if (mrsp.done) begin
                    rmag_next  = mrsp.value;
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                if (rclip > peak_res_reg) begin
                    peak_res_next = rclip;
                end
                if (spd_reg > peak_spd_reg) begin
                    peak_spd_next = spd_reg;
                end
                flag_next   = 1'b0;
                sq_v_next   = (spd_reg > peak_spd_reg) ? spd_reg : peak_spd_reg;
                sq_res_next = '0;
                sq_bit_next = 64'h4000_0000_0000_0000;
                sq_cnt_next = '0;
                if (!cur_reg.last) begin
                    state_next = ST_IDLE;
                end else if (cfg.step_mode == STEP_ZERO_VEL) begin
                    state_next = ST_ZV;
                end else begin
                    state_next = ST_SQRT;
                end
            end
            ST_ZV: begin
                if (mrsp.done) begin
                    tmp_next   = {32'd0, mrsp.value[31:0]};
                    state_next = ST_CLAMP;
                end
            end
            ST_SQRT: begin
                if (sq_v_reg >= sq_sum) begin
                    sq_v_next   = sq_v_reg - sq_sum;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                sq_cnt_next = sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == 5'd31) begin
                    vmax_next  = sq_res_next[31:0];
                    state_next = ST_B1;
                end
            end
            ST_B1: begin
                if (mrsp.done) begin
                    tmp_next   = mrsp.value;
                    flag_next  = flag_reg | mrsp.sat;
                    state_next = ST_B2;
                end
            end
            ST_B2: begin
                if (mrsp.done) begin
                    bound_next = mrsp.value;
                    tmp_next   = mrsp.value;
                    flag_next  = flag_reg | mrsp.sat;
                    if (cfg.step_mode == STEP_FIRST) begin
                        state_next = ST_CLAMP;
                    end else begin
                        flag_next  = flag_reg | mrsp.sat | (peak_res_reg == 32'hFFFF_FFFF);
                        state_next = ST_E0;
                    end
                end
            end
            ST_E0: begin
                if (mrsp.done) begin
                    tmp_next   = mrsp.value;
                    flag_next  = flag_reg | mrsp.sat;
                    state_next = ST_E1;
                end
            end
            ST_E1: begin
                if (mrsp.done) begin
                    tmp_next   = mrsp.value;
                    flag_next  = flag_reg | mrsp.sat;
                    state_next = ST_E2;
                end
            end
            ST_E2: begin
                if (mrsp.done) begin
                    tmp_next   = mrsp.value;
                    flag_next  = flag_reg | mrsp.sat;
                    state_next = ST_E3;
                end
            end
            ST_E3: begin
                if (mrsp.done) begin
                    tmp_next   = (mrsp.value < bound_reg) ? mrsp.value : bound_reg;
                    flag_next  = flag_reg | mrsp.sat;
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_visc_next  = (tmp_reg > MASK32) ? 32'hFFFF_FFFF : tmp_reg[31:0];
                    out_sat_next   = flag_reg | (tmp_reg > MASK32);
                    peak_res_next  = '0;
                    peak_spd_next  = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            peak_res_reg  <= '0;
            peak_spd_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            peak_res_reg  <= peak_res_next;
            peak_spd_reg  <= peak_spd_next;
            out_valid_reg <= out_valid_next;
        end
        cur_reg      <= cur_next;
        acc_reg      <= acc_next;
        spd_reg      <= spd_next;
        rmag_reg     <= rmag_next;
        sq_v_reg     <= sq_v_next;
        sq_res_reg   <= sq_res_next;
        sq_bit_reg   <= sq_bit_next;
        sq_cnt_reg   <= sq_cnt_next;
        vmax_reg     <= vmax_next;
        tmp_reg      <= tmp_next;
        bound_reg    <= bound_next;
        flag_reg     <= flag_next;
        out_visc_reg <= out_visc_next;
        out_sat_reg  <= out_sat_next;
    end

endmodule

[design/entropy_viscosity_advection_core.sv]
// Entropy-viscosity core: one quadrature point per item, one viscosity per cell on the
// point marked last. The front stage registers and averages each point and hands it to a
// two-entry queue, so new points are taken while the back end works. The back end runs one
// point at a time through a shared 64x33 multiplier. On the last point of a cell, a
// square-root iteration and up to six further products follow (a single product and no
// square root for a zero-velocity step). Configuration is written through its own port,
// which is always ready, and must only be written while the core is idle.
module entropy_viscosity_advection_core
    import eva_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_conc_now,
    input  logic [31:0] s_conc_before,
    input  logic [31:0] s_grad_now_x,
    input  logic [31:0] s_grad_now_y,
    input  logic [31:0] s_grad_before_x,
    input  logic [31:0] s_grad_before_y,
    input  logic [31:0] s_vel_now_x,
    input  logic [31:0] s_vel_now_y,
    input  logic [31:0] s_vel_before_x,
    input  logic [31:0] s_vel_before_y,
    input  logic [31:0] s_cell_size,
    input  logic        s_last_point,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_viscosity,
    output logic        m_saturated
);

    cfg_t     cfg_reg;
    entry_t   f_entry;
    entry_t   q_entry;
    logic     f_valid;
    logic     f_ready;
    logic     q_valid;
    logic     q_ready;
    mul_req_t mreq;
    mul_rsp_t mrsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_mode    <= 2'd2;
            cfg_reg.entropy_mode <= 1'b0;
            cfg_reg.beta         <= '0;
            cfg_reg.resid        <= '0;
            cfg_reg.inv_dt       <= '0;
            cfg_reg.mean         <= '0;
            cfg_reg.inv_ev       <= '0;
            cfg_reg.dscale       <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_STEP_MODE:    cfg_reg.step_mode    <= cfg_data[1:0];
                CFG_ENTROPY_MODE: cfg_reg.entropy_mode <= cfg_data[0];
                CFG_BETA:         cfg_reg.beta         <= cfg_data;
                CFG_RESIDUAL:     cfg_reg.resid        <= cfg_data;
                CFG_INV_DT:       cfg_reg.inv_dt       <= cfg_data;
                CFG_MEAN:         cfg_reg.mean         <= cfg_data;
                CFG_INV_EV:       cfg_reg.inv_ev       <= cfg_data;
                CFG_DSCALE:       cfg_reg.dscale       <= cfg_data;
                default:          cfg_reg.dscale       <= cfg_reg.dscale;
            endcase
        end
    end

    eva_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_conc_now      (s_conc_now),
        .s_conc_before   (s_conc_before),
        .s_grad_now_x    (s_grad_now_x),
        .s_grad_now_y    (s_grad_now_y),
        .s_grad_before_x (s_grad_before_x),
        .s_grad_before_y (s_grad_before_y),
        .s_vel_now_x     (s_vel_now_x),
        .s_vel_now_y     (s_vel_now_y),
        .s_vel_before_x  (s_vel_before_x),
        .s_vel_before_y  (s_vel_before_y),
        .s_cell_size     (s_cell_size),
        .s_last_point    (s_last_point),
        .out_valid       (f_valid),
        .out_ready       (f_ready),
        .out_entry       (f_entry)
    );

    eva_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_entry),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_entry)
    );

    eva_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    eva_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_data      (q_entry),
        .mreq        (mreq),
        .mrsp        (mrsp),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_viscosity (m_viscosity),
        .m_saturated (m_saturated)
    );

endmodule

[design/eva_checker.sv]
module eva_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last_point,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_viscosity,
    input logic        m_saturated
);

    logic [3:0] pend_reg;
    logic       s_last_acc;
    logic       m_acc;

    assign s_last_acc = s_valid && s_ready && s_last_point;
    assign m_acc      = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else if (s_last_acc && !m_acc) begin
            pend_reg <= pend_reg + 1'b1;
        end else if (m_acc && !s_last_acc) begin
            pend_reg <= pend_reg - 1'b1;
        end
    end

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn before it was taken");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_viscosity) && $stable(m_saturated))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    a_result_owed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 4'd0)
        else $error("result without a pending last point");

endmodule

bind entropy_viscosity_advection_core eva_checker u_eva_checker (.*);

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
    import eva_pkg::*;

    typedef struct {
        logic [31:0] conc_now;
        logic [31:0] conc_before;
        logic [31:0] grad_now_x;
        logic [31:0] grad_now_y;
        logic [31:0] grad_before_x;
        logic [31:0] grad_before_y;
        logic [31:0] vel_now_x;
        logic [31:0] vel_now_y;
        logic [31:0] vel_before_x;
        logic [31:0] vel_before_y;
        logic [31:0] cell_size;
        logic        last_point;
    } point_t;

    typedef struct {
        logic [31:0] viscosity;
        logic        saturated;
    } visc_t;

    localparam int F = 16;
    localparam logic [63:0] ZERO_VEL_COEF = ((64'd5 << F) + 64'd500) / 64'd1000;
    localparam logic [63:0] MAX32 = 64'hFFFF_FFFF;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_conc_now = '0, s_conc_before = '0;
    logic [31:0] s_grad_now_x = '0, s_grad_now_y = '0;
    logic [31:0] s_grad_before_x = '0, s_grad_before_y = '0;
    logic [31:0] s_vel_now_x = '0, s_vel_now_y = '0;
    logic [31:0] s_vel_before_x = '0, s_vel_before_y = '0;
    logic [31:0] s_cell_size = '0;
    logic        s_last_point = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_viscosity;
    logic        m_saturated;

    entropy_viscosity_advection_core dut (.*);

    always #5 aclk = ~aclk;

    point_t      pending_points[$];
    visc_t       viscosity_q[$];
    point_t      cur_point;
    cfg_t        model_cfg;
    logic [31:0] peak_residual;
    logic [63:0] peak_speed_sq;
    bit          chain_sat;
    bit          no_gaps;
    int          send_gap;
    int          recv_stall;
    int          errors;

    function automatic longint sx(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic logic [63:0] mag(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        logic [127:0] pr;
        pr = {64'b0, a} * {64'b0, b};
        if (pr[127:64+F] != 0) begin
            chain_sat = 1'b1;
            return '1;
        end
        return pr[64+F-1:F];
    endfunction

    function automatic longint smul(longint a, longint b);
        logic [63:0] m;
        m = qmul(mag(a), mag(b));
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic void predict_viscosity(point_t p);
        longint cn, cb, gx, gy, ux, uy, ug, t;
        logic [63:0] rmag, speed, vmax, bound, ev, result;
        visc_t v;
        cn = sx(p.conc_now);
        cb = sx(p.conc_before);
        gx = (sx(p.grad_now_x) + sx(p.grad_before_x)) / 2;
        gy = (sx(p.grad_now_y) + sx(p.grad_before_y)) / 2;
        ux = (sx(p.vel_now_x) + sx(p.vel_before_x)) / 2;
        uy = (sx(p.vel_now_y) + sx(p.vel_before_y)) / 2;
        ug = smul(ux, gx) + smul(uy, gy);
        speed = mag(ux) * mag(ux) + mag(uy) * mag(uy);
        rmag = mag(smul(cn - cb, longint'({32'b0, model_cfg.inv_dt})) + ug);
        if (model_cfg.entropy_mode) begin
            t = (cn + cb) / 2;
            rmag = qmul(rmag, mag(t - sx(model_cfg.mean)));
        end
        if (rmag > MAX32) rmag = MAX32;
        if (rmag[31:0] > peak_residual) peak_residual = rmag[31:0];
        if (speed > peak_speed_sq) peak_speed_sq = speed;
        if (!p.last_point) return;

        chain_sat = 1'b0;
        if (model_cfg.step_mode == STEP_ZERO_VEL) begin
            result = ({32'b0, p.cell_size} * ZERO_VEL_COEF) >> F;
        end else begin
            vmax = isqrt(peak_speed_sq);
            bound = qmul(qmul({32'b0, model_cfg.beta}, vmax), {32'b0, p.cell_size});
            if (model_cfg.step_mode == STEP_FIRST) begin
                result = bound;
            end else begin
                if (peak_residual == 32'hFFFF_FFFF) chain_sat = 1'b1;
                ev = qmul({32'b0, model_cfg.resid}, {32'b0, p.cell_size});
                if (model_cfg.entropy_mode) begin
                    ev = qmul(ev, {32'b0, p.cell_size});
                    ev = qmul(ev, {32'b0, peak_residual});
                    ev = qmul(ev, {32'b0, model_cfg.inv_ev});
                end else begin
                    ev = qmul(ev, {32'b0, model_cfg.dscale});
                    ev = qmul(ev, vmax);
                    ev = qmul(ev, {32'b0, peak_residual});
                end
                result = ev < bound ? ev : bound;
            end
            if (result > MAX32) begin
                result = MAX32;
                chain_sat = 1'b1;
            end
        end
        v.viscosity = result[31:0];
        v.saturated = chain_sat;
        viscosity_q.push_back(v);
        peak_residual = '0;
        peak_speed_sq = '0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mostly modest magnitudes so the arithmetic stays in range, with full and extreme values mixed in.
    function automatic logic [31:0] rand_field(bit is_signed);
        int r;
        logic [31:0] v;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            v = $urandom_range(0, 32'h3FFFF);
            if (is_signed && $urandom_range(0, 1)) v = -v;
        end else if (r < 85) begin
            v = $urandom;
        end else begin
            case ($urandom_range(0, 3))
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'h0000_0000;
                default: v = 32'hFFFF_FFFF;
            endcase
        end
        return v;
    endfunction

    function automatic point_t rand_point(bit last);
        point_t p;
        p.conc_now = rand_field(1);
        p.conc_before = rand_field(1);
        p.grad_now_x = rand_field(1);
        p.grad_now_y = rand_field(1);
        p.grad_before_x = rand_field(1);
        p.grad_before_y = rand_field(1);
        p.vel_now_x = rand_field(1);
        p.vel_now_y = rand_field(1);
        p.vel_before_x = rand_field(1);
        p.vel_before_y = rand_field(1);
        p.cell_size = rand_field(0);
        p.last_point = last;
        return p;
    endfunction

    function automatic point_t const_point(logic [31:0] v, logic [31:0] h, bit last);
        point_t p;
        p = '{v, v, v, v, v, v, v, v, v, v, h, last};
        return p;
    endfunction

    function automatic logic [31:0] rand_coeff(int kind);
        if (kind == 1) return 32'hFFFF_FFFF;
        if (kind == 2) return 32'h0;
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 32'h3FFFF);
            1: return $urandom_range(0, 32'hFFFFF);
            2: return $urandom_range(0, 32'h1FFFF);
            default: return $urandom;
        endcase
    endfunction

    task automatic write_config(logic [1:0] mode, logic ent, int kind);
        logic [31:0] vals[8];
        vals[CFG_STEP_MODE] = {30'b0, mode};
        vals[CFG_ENTROPY_MODE] = {31'b0, ent};
        for (int i = 2; i < 8; i++) vals[i] = rand_coeff(kind);
        if (kind == 0) vals[CFG_MEAN] = rand_field(1);
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            case (3'(i))
                CFG_STEP_MODE:    model_cfg.step_mode = vals[i][1:0];
                CFG_ENTROPY_MODE: model_cfg.entropy_mode = vals[i][0];
                CFG_BETA:         model_cfg.beta = vals[i];
                CFG_RESIDUAL:     model_cfg.resid = vals[i];
                CFG_INV_DT:       model_cfg.inv_dt = vals[i];
                CFG_MEAN:         model_cfg.mean = vals[i];
                CFG_INV_EV:       model_cfg.inv_ev = vals[i];
                CFG_DSCALE:       model_cfg.dscale = vals[i];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0 || s_valid || viscosity_q.size() != 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("tb: mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        bit busy;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                predict_viscosity(cur_point);
                busy = 1'b0;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_points.size() != 0) begin
                    cur_point = pending_points.pop_front();
                    s_conc_now <= cur_point.conc_now;
                    s_conc_before <= cur_point.conc_before;
                    s_grad_now_x <= cur_point.grad_now_x;
                    s_grad_now_y <= cur_point.grad_now_y;
                    s_grad_before_x <= cur_point.grad_before_x;
                    s_grad_before_y <= cur_point.grad_before_y;
                    s_vel_now_x <= cur_point.vel_now_x;
                    s_vel_now_y <= cur_point.vel_now_y;
                    s_vel_before_x <= cur_point.vel_before_x;
                    s_vel_before_y <= cur_point.vel_before_y;
                    s_cell_size <= cur_point.cell_size;
                    s_last_point <= cur_point.last_point;
                    s_valid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        visc_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (viscosity_q.size() == 0) begin
                    $display("tb: unexpected item at %0t: viscosity %h", $realtime, m_viscosity);
                    errors++;
                end else begin
                    want = viscosity_q.pop_front();
                    if (m_viscosity !== want.viscosity)
                        report_mismatch("viscosity", m_viscosity, want.viscosity);
                    if (m_saturated !== want.saturated)
                        report_mismatch("saturated", {31'b0, m_saturated},
                                        {31'b0, want.saturated});
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_stall = pick_gap();
            end
        end
    end

    initial begin
        int npts;
        model_cfg = '{2'd2, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
        peak_residual = '0;
        peak_speed_sq = '0;
        errors = 0;
        send_gap = 0;
        recv_stall = 0;
        no_gaps = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corner points under a moderate normal-step setting.
        write_config(2'd2, 1'b0, 0);
        pending_points.push_back(const_point(32'h0, 32'h0, 1'b1));
        pending_points.push_back(const_point(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        pending_points.push_back(const_point(32'h8000_0000, 32'hFFFF_FFFF, 1'b1));
        pending_points.push_back(const_point(32'hFFFF_FFFF, 32'h0001_0000, 1'b0));
        pending_points.push_back(const_point(32'h0001_0000, 32'h0001_0000, 1'b1));
        for (int i = 0; i < 6; i++) pending_points.push_back(rand_point(i == 5));
        wait_drained();
        write_config(2'd2, 1'b1, 0);
        pending_points.push_back(const_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        pending_points.push_back(const_point(32'h0002_0000, 32'h0000_8000, 1'b1));
        for (int i = 0; i < 4; i++) pending_points.push_back(rand_point(i == 3));
        wait_drained();
        write_config(2'd1, 1'b0, 1);
        pending_points.push_back(const_point(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        pending_points.push_back(const_point(32'h0001_0000, 32'h0001_0000, 1'b1));
        wait_drained();
        write_config(2'd0, 1'b1, 2);
        pending_points.push_back(const_point(32'h1234_5678, 32'hFFFF_FFFF, 1'b1));
        pending_points.push_back(const_point(32'h0, 32'h0, 1'b1));
        wait_drained();
        write_config(2'd3, 1'b1, 1);
        pending_points.push_back(const_point(32'h0001_0000, 32'h0001_0000, 1'b1));
        pending_points.push_back(rand_point(1'b1));

        for (int phase = 0; phase < 14; phase++) begin
            wait_drained();
            no_gaps = (phase % 4 == 3);
            write_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         phase == 5 ? 1 : (phase == 9 ? 2 : 0));
            for (int c = 0; c < 12; c++) begin
                npts = $urandom_range(1, 7);
                for (int k = 0; k < npts; k++) pending_points.push_back(rand_point(k == npts - 1));
                if ($urandom_range(0, 9) == 0) pending_points.push_back(rand_point(1'b0));
            end
        end
        wait_drained();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

endmodule
